@@ rtl/sfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, register codes and helpers for the stream find/replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int CNT_W      = 5;    // counts 0..16
    localparam int REPL_MAX   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_HIGH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REPL_LEN     = 3'd5;

    // One queued output job: either the replacement string, or a run of text
    // made of pattern bytes 0..held-1 followed by the input byte.
    typedef struct packed {
        logic             is_repl;
        logic [CNT_W-1:0] count;   // bytes to emit, 0 = bare end marker
        logic [CNT_W-1:0] held;    // pattern bytes ahead of the input byte
        logic [7:0]       data;    // input byte
        logic             last;
    } sfr_job_t;

    function automatic logic [7:0] byte_of(input logic [63:0] lo,
                                           input logic [63:0] hi,
                                           input logic [3:0]  idx);
        logic [63:0] w;
        w = idx[3] ? hi : lo;
        return w[{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

@@ rtl/sfr_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_cell
// One match cell: holds the "prefix of length j+1 ends here" bit and extends
// the bit handed over by its left neighbor when the new byte fits.
// ----------------------------------------------------------------------------
module sfr_cell (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic       clear,
    input  wire logic       active,
    input  wire logic       prev_match,
    input  wire logic [7:0] pat_byte,
    input  wire logic [7:0] in_byte,
    output logic            hit,
    output logic            match
);

    logic match_reg;

    assign hit   = active & prev_match & (in_byte == pat_byte);
    assign match = match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (clear) begin
            match_reg <= 1'b0;
        end else if (step) begin
            match_reg <= hit;
        end
    end

endmodule
`default_nettype wire

@@ rtl/sfr_match.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_match
// Row of match cells plus held-byte count; turns each input byte into at most
// one output job (released text, or the replacement on a full match).
// ----------------------------------------------------------------------------
module sfr_match
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step,
    input  wire logic             pat_wr,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_last,
    input  wire logic [63:0]      pattern_low,
    input  wire logic [63:0]      pattern_high,
    input  wire logic [CNT_W-1:0] pattern_len,
    input  wire logic [CNT_W-1:0] repl_len,
    output logic                  job_valid,
    output sfr_job_t              job
);

    logic [CNT_W-1:0]       held_reg;
    logic [CNT_W-1:0]       held_next;
    logic [CNT_W-1:0]       eff_len;
    logic [CNT_W-1:0]       rl;
    logic [CNT_W-1:0]       h_new;
    logic [CNT_W-1:0]       text_cnt;
    logic                   full;
    logic                   clear;
    logic [MAX_PATTERN-1:0] hit;
    logic [MAX_PATTERN-1:0] match;
    logic [MAX_PATTERN-1:0] prev;
    logic [MAX_PATTERN-1:0] active;

    assign eff_len = (pattern_len > CNT_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : pattern_len;
    assign rl      = (repl_len > CNT_W'(REPL_MAX)) ? CNT_W'(REPL_MAX) : repl_len;

    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign prev[j] = 1'b1;
        end else begin : g_link
            assign prev[j] = match[j-1];
        end
        assign active[j] = CNT_W'(j) < eff_len;

        sfr_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .step       (step),
            .clear      (clear),
            .active     (active[j]),
            .prev_match (prev[j]),
            .pat_byte   (byte_of(pattern_low, pattern_high, 4'(j))),
            .in_byte    (in_byte),
            .hit        (hit[j]),
            .match      (match[j])
        );
    end

    // full match at the last active cell; longest surviving prefix otherwise
    always_comb begin
        full  = 1'b0;
        h_new = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (hit[j] && (CNT_W'(j + 1) == eff_len)) begin
                full = 1'b1;
            end
            if (hit[j]) begin
                h_new = CNT_W'(j + 1);
            end
        end
    end

    // a pattern write, a full match or the end of the stream empties the window
    assign clear    = pat_wr | (step & (full | in_last));
    assign text_cnt = held_reg + CNT_W'(1) - h_new;

    always_comb begin
        job.is_repl = full;
        job.held    = held_reg;
        job.data    = in_byte;
        job.last    = in_last;
        if (full) begin
            job.count = rl;
        end else if (in_last) begin
            job.count = held_reg + CNT_W'(1);
        end else begin
            job.count = text_cnt;
        end
    end

    assign job_valid = step & ((job.count != '0) | in_last);

    always_comb begin
        held_next = held_reg;
        if (pat_wr) begin
            held_next = '0;
        end else if (step) begin
            held_next = (full | in_last) ? '0 : h_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else begin
            held_reg <= held_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/sfr_emit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_emit
// Two-entry job queue and output register; expands each job into bytes.
// ----------------------------------------------------------------------------
module sfr_emit
    import sfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire sfr_job_t    push_job,
    output logic             push_ready,
    input  wire logic [63:0] pattern_low,
    input  wire logic [63:0] pattern_high,
    input  wire logic [63:0] repl_low,
    input  wire logic [63:0] repl_high,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    sfr_job_t   job_mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic [3:0] idx_reg;
    logic [3:0] idx_next;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tuser_reg;
    logic       m_tlast_reg;

    sfr_job_t   head;
    logic       load;
    logic       beat_final;
    logic       pop;
    logic [7:0] beat_byte;

    assign head       = job_mem_reg[rd_ptr_reg];
    assign load       = (fill_reg != 2'd0) & (~m_tvalid_reg | m_tready);
    assign beat_final = (head.count == '0) || ((CNT_W'(idx_reg) + CNT_W'(1)) == head.count);
    assign pop        = load & beat_final;
    assign push_ready = fill_reg != 2'd2;

    always_comb begin
        if (head.count == '0) begin
            beat_byte = 8'd0;
        end else if (head.is_repl) begin
            beat_byte = byte_of(repl_low, repl_high, idx_reg);
        end else if (CNT_W'(idx_reg) < head.held) begin
            beat_byte = byte_of(pattern_low, pattern_high, idx_reg);
        end else begin
            beat_byte = head.data;
        end
    end

    always_comb begin
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
        idx_next = idx_reg;
        if (load) begin
            idx_next = beat_final ? 4'd0 : idx_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            fill_reg     <= 2'd0;
            idx_reg      <= 4'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            job_mem_reg[wr_ptr_reg] <= push_job;
        end
        if (load) begin
            m_tdata_reg <= beat_byte;
            m_tuser_reg <= head.count != '0;
            m_tlast_reg <= head.last & beat_final;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire

@@ rtl/stream_find_replace.sv @@
`default_nettype none
// A byte's first result passes through the job queue, then the output register.
// Throughput: one input byte per cycle while the job queue has room; a byte's n results
//   go out in turn (replacement bursts, flush on tlast), buffered by a 2-entry job queue.
// The match decision is made in the cycle of the transfer by a row of MAX_PATTERN cells.
// Reset (aresetn, synchronous): clears match cells, held count, job queue, output valid
//   and all configuration registers.
// ----------------------------------------------------------------------------
// stream_find_replace
// Byte stream find/replace: each leftmost non-overlapping occurrence of the
// pattern is replaced; held bytes are flushed on tlast.
// ----------------------------------------------------------------------------
module stream_find_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] in_byte
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_byte
    output logic                       m_tuser,   // [0] byte_valid
    output logic                       m_tlast
);

    logic [63:0]      pattern_low_reg;
    logic [63:0]      pattern_high_reg;
    logic [CNT_W-1:0] pattern_len_reg;
    logic [63:0]      repl_low_reg;
    logic [63:0]      repl_high_reg;
    logic [CNT_W-1:0] repl_len_reg;
    logic             pat_wr;
    logic             step;
    logic             job_valid;
    sfr_job_t         job;

    always_comb begin
        pat_wr = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_LOW,
                REG_PATTERN_HIGH,
                REG_PATTERN_LEN: pat_wr = 1'b1;
                default:         pat_wr = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg  <= '0;
            pattern_high_reg <= '0;
            pattern_len_reg  <= '0;
            repl_low_reg     <= '0;
            repl_high_reg    <= '0;
            repl_len_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PATTERN_LOW:  pattern_low_reg  <= cfg_wdata;
                REG_PATTERN_HIGH: pattern_high_reg <= cfg_wdata;
                REG_PATTERN_LEN:  pattern_len_reg  <= cfg_wdata[CNT_W-1:0];
                REG_REPL_LOW:     repl_low_reg     <= cfg_wdata;
                REG_REPL_HIGH:    repl_high_reg    <= cfg_wdata;
                REG_REPL_LEN:     repl_len_reg     <= cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign step = s_tvalid & s_tready;

    sfr_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .pat_wr       (pat_wr),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .pattern_low  (pattern_low_reg),
        .pattern_high (pattern_high_reg),
        .pattern_len  (pattern_len_reg),
        .repl_len     (repl_len_reg),
        .job_valid    (job_valid),
        .job          (job)
    );

    sfr_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (job_valid),
        .push_job     (job),
        .push_ready   (s_tready),
        .pattern_low  (pattern_low_reg),
        .pattern_high (pattern_high_reg),
        .repl_low     (repl_low_reg),
        .repl_high    (repl_high_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

endmodule
`default_nettype wire

@@ sim/stream_find_replace_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_find_replace_test
// Self-checking bench for the stream find/replace block. A local model of the
// match window predicts every output transfer. Directed cases cover
// pass-through, overlapping prefixes, deletion, bare end markers, pattern
// rewrites, ignored register indexes and a long output hold. Random phases then sweep the
// pattern and replacement settings under bursty input and output stalls.
// ----------------------------------------------------------------------------
module stream_find_replace_test;
    import sfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 260;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
    } text_out_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = 8'h00;   // [7:0] in_byte
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;             // [7:0] out_byte
    logic                  m_tuser;             // [0] byte_valid
    logic                  m_tlast;

    // register mirror and match window of the local model
    logic [63:0] pat_lo, pat_hi, rep_lo, rep_hi;
    logic [4:0]  pat_len_q, rep_len_q;
    logic [7:0]  win [16];
    int          held_n;

    text_out_t   expected_bytes [$];
    text_out_t   want;
    int          errors       = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;
    bit          tx_bursty    = 1'b0;
    rx_mode_t    rx_mode      = RX_ALWAYS;
    int          rx_period    = 3;
    int          rx_phase     = 0;
    int          hold_request = 0;
    int          hold_left    = 0;
    int          quiet_cycles = 0;

    stream_find_replace i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_byte(input logic [63:0] lo, input logic [63:0] hi,
                                             input int idx);
        return (idx < 8) ? lo[idx*8 +: 8] : hi[(idx-8)*8 +: 8];
    endfunction

    // emit the oldest held byte and shift the window down
    function automatic void release_oldest();
        expected_bytes.push_back({win[0], 1'b1, 1'b0});
        for (int i = 0; i < 15; i++)
            win[i] = win[i+1];
        held_n--;
    endfunction

    function automatic void predict_replace(input logic [7:0] b, input logic last);
        int        len;
        int        rl;
        int        base;
        bit        prefix;
        text_out_t tail;
        base = expected_bytes.size();
        len  = (pat_len_q > 5'd16) ? 16 : int'(pat_len_q);
        rl   = (rep_len_q > 5'd16) ? 16 : int'(rep_len_q);
        if (len == 0) begin
            while (held_n > 0)
                release_oldest();
            expected_bytes.push_back({b, 1'b1, 1'b0});
        end else begin
            if (held_n >= len)
                held_n = 0;
            win[held_n] = b;
            held_n++;
            while (held_n > 0) begin
                prefix = 1'b1;
                for (int i = 0; i < held_n; i++)
                    if (win[i] != pick_byte(pat_lo, pat_hi, i))
                        prefix = 1'b0;
                if (prefix) begin
                    if (held_n == len) begin
                        for (int i = 0; i < rl; i++)
                            expected_bytes.push_back({pick_byte(rep_lo, rep_hi, i),
                                                      1'b1, 1'b0});
                        held_n = 0;
                    end
                    break;
                end
                release_oldest();
            end
        end
        if (last) begin
            while (held_n > 0)
                release_oldest();
            // nothing emitted for this byte: bare end marker
            if (expected_bytes.size() == base)
                expected_bytes.push_back({8'h00, 1'b0, 1'b0});
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:  begin pat_lo = value;         held_n = 0; end
            REG_PATTERN_HIGH: begin pat_hi = value;         held_n = 0; end
            REG_PATTERN_LEN:  begin pat_len_q = value[4:0]; held_n = 0; end
            REG_REPL_LOW:     rep_lo = value;
            REG_REPL_HIGH:    rep_hi = value;
            REG_REPL_LEN:     rep_len_q = value[4:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [63:0] plo, input logic [63:0] phi,
                              input logic [63:0] plen, input logic [63:0] rlo,
                              input logic [63:0] rhi, input logic [63:0] rlen);
        write_reg(REG_PATTERN_LOW, plo);
        write_reg(REG_PATTERN_HIGH, phi);
        write_reg(REG_PATTERN_LEN, plen);
        write_reg(REG_REPL_LOW, rlo);
        write_reg(REG_REPL_HIGH, rhi);
        write_reg(REG_REPL_LEN, rlen);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = tx_bursty ? $urandom_range(1, 5) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_replace(b, last);
        items_sent++;
    endtask

    // drop valid, wait for every predicted transfer, then let the pipe drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic coin_last();
        return $urandom_range(0, 23) == 0;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // registers at reset give an empty pattern
    task automatic test_passthrough_after_reset();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        settle();
    endtask

    // pattern "aab": the third 'a' forces release of the oldest held byte
    task automatic test_replace_overlap();
        set_config(64'hF0E1_D2C3_B462_6161, 64'h0123_4567_89AB_CDEF, 64'd3,
                   64'hFFFF_FFFF_FF5A_5958, 64'hFFFF_FFFF_FFFF_FFFF, 64'd3);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b1);   // flushes the held byte with the input byte
        settle();
    endtask

    // empty replacement: a match at the end leaves only the end marker
    task automatic test_delete_end_marker();
        write_reg(REG_REPL_LEN, 64'd0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        send_byte(8'h61, 1'b1);
        settle();
    endtask

    // held bytes are dropped by a pattern write
    task automatic test_pattern_rewrite();
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        settle();
        write_reg(REG_PATTERN_LEN, 64'd3);
        send_byte(8'h62, 1'b1);
        settle();
    endtask

    task automatic test_ignored_index();
        write_reg(REG_UNUSED_6, '1);
        write_reg(REG_UNUSED_7, '1);
        send_byte(8'h61, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b1);
        settle();
    endtask

    // long receiver hold with 16-byte bursts fills the block and stalls input
    task automatic test_backpressure();
        set_config(64'h0000_0000_0000_002A, {$urandom, $urandom}, 64'd1,
                   {$urandom, $urandom}, {$urandom, $urandom}, 64'd16);
        tx_bursty    = 1'b0;
        rx_mode      = RX_ALWAYS;
        hold_request = 300;
        for (int i = 0; i < 40; i++)
            send_byte(($urandom_range(0, 4) != 0) ? 8'h2A : 8'($urandom), coin_last());
        settle();
    endtask

    task automatic test_random_streams();
        int          phase;
        int          quota;
        int          start;
        int          eff;
        int          cut;
        int          r;
        logic [7:0]  sym [3];
        logic [63:0] plo, phi, plen, rlen;
        logic [7:0]  nb;
        phase = 0;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            foreach (sym[k])
                sym[k] = 8'($urandom);
            plen = {$urandom, $urandom};
            rlen = {$urandom, $urandom};
            case (phase)
                0: begin plen[4:0] = 5'd16; rlen[4:0] = 5'd16; end
                1: begin plen[4:0] = 5'd31; rlen[4:0] = 5'd31; end
                2: begin plen[4:0] = 5'd0;  rlen[4:0] = 5'($urandom_range(0, 16)); end
                3: begin plen[4:0] = 5'($urandom_range(1, 4)); rlen[4:0] = 5'd0; end
                default: begin
                    plen[4:0] = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(1, 4))
                                                            : 5'($urandom_range(5, 31));
                    rlen[4:0] = 5'($urandom_range(0, 31));
                end
            endcase
            eff = (plen[4:0] > 5'd16) ? 16 : int'(plen[4:0]);
            plo = {$urandom, $urandom};
            phi = {$urandom, $urandom};
            for (int i = 0; i < eff; i++)
                if (i < 8)
                    plo[i*8 +: 8] = sym[$urandom_range(0, 2)];
                else
                    phi[(i-8)*8 +: 8] = sym[$urandom_range(0, 2)];
            set_config(plo, phi, plen, {$urandom, $urandom}, {$urandom, $urandom}, rlen);
            if ($urandom_range(0, 3) == 0)
                write_reg(($urandom_range(0, 1) != 0) ? REG_UNUSED_6 : REG_UNUSED_7,
                          {$urandom, $urandom});

            tx_bursty = ($urandom_range(0, 3) != 0);
            rx_mode   = rx_mode_t'($urandom_range(0, 2));
            rx_period = $urandom_range(2, 5);
            quota     = items_sent + $urandom_range(20, 35);
            while (items_sent < quota) begin
                r = $urandom_range(0, 7);
                if (eff == 0 || r < 2) begin
                    nb = ($urandom_range(0, 1) != 0) ? 8'($urandom) : sym[$urandom_range(0, 2)];
                    send_byte(nb, coin_last());
                end else if (r < 5) begin
                    for (int i = 0; i < eff; i++)
                        send_byte(pick_byte(pat_lo, pat_hi, i), coin_last());
                end else begin
                    // partial match followed by a likely mismatch
                    cut = $urandom_range(1, eff);
                    for (int i = 0; i < cut - 1; i++)
                        send_byte(pick_byte(pat_lo, pat_hi, i), coin_last());
                    send_byte(sym[$urandom_range(0, 2)], coin_last());
                end
            end
            settle();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver, checker, watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        rx_phase = rx_phase + 1;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
                default:   m_tready <= ((rx_phase % rx_period) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected transfer data=%h user=%b last=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.byte_valid) begin
                    $display("%0t: byte_valid expected %b actual %b",
                             $time, want.byte_valid, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: out_last expected %b actual %b", $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** stream_find_replace: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        pat_lo    = '0;
        pat_hi    = '0;
        pat_len_q = '0;
        rep_lo    = '0;
        rep_hi    = '0;
        rep_len_q = '0;
        held_n    = 0;
        foreach (win[k])
            win[k] = 8'h00;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_bursty = 1'b1;
        rx_mode   = RX_RANDOM;
        test_passthrough_after_reset();
        test_replace_overlap();
        rx_mode   = RX_PERIODIC;
        test_delete_end_marker();
        test_pattern_rewrite();
        test_ignored_index();
        test_backpressure();
        test_random_streams();

        settle();
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("** stream_find_replace: PASSED **");
        end else begin
            $display("** stream_find_replace: FAILED **");
        end
        $finish;
    end

endmodule
